FILE: rtl/voqrr_pkg.sv
`default_nettype none
// ============================================================================
// voqrr_pkg
// Shared types, constants and helpers of the round-robin VOQ arbiter.
// ============================================================================
package voqrr_pkg;

   localparam int MAX_SOURCES = 8;
   localparam int MAX_DESTS   = 8;
   localparam int SRC_W       = 3;
   localparam int DST_W       = 3;
   localparam int CNT_W       = 4;
   localparam int MAP_W       = MAX_SOURCES * MAX_DESTS;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DESTS   = CSR_IDX_W'(1);

   typedef struct packed {
      logic [MAP_W-1:0]     ready_map;
      logic [MAX_DESTS-1:0] output_free;
   } req_type;

   typedef struct packed {
      logic             grant_valid;
      logic [SRC_W-1:0] grant_source;
      logic [DST_W-1:0] grant_dest;
      logic             last_grant;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_more;
      logic out_can_load;
   } status_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > lim) begin
         r = lim;
      end
      return r;
   endfunction

   function automatic logic [MAP_W-1:0] ready_mask(input logic [CNT_W-1:0] ns,
                                                   input logic [CNT_W-1:0] nd);
      logic [MAP_W-1:0] m;
      m = '0;
      for (int s = 0; s < MAX_SOURCES; s++) begin
         for (int d = 0; d < MAX_DESTS; d++) begin
            m[s*MAX_DESTS+d] = (CNT_W'(s) < ns) && (CNT_W'(d) < nd);
         end
      end
      return m;
   endfunction

   function automatic logic [MAX_DESTS-1:0] dest_mask(input logic [CNT_W-1:0] nd);
      logic [MAX_DESTS-1:0] m;
      m = '0;
      for (int d = 0; d < MAX_DESTS; d++) begin
         m[d] = CNT_W'(d) < nd;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/voqrr_ctrl.sv
`default_nettype none
// ============================================================================
// voqrr_ctrl
// Sequencer of the arbiter: takes a request, steps the input scan, emits the
// closing result.
// ============================================================================
module voqrr_ctrl
   import voqrr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.scan_more) begin
               state_in = ST_FINISH;
            end else if (status.out_can_load) begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_can_load) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/voqrr_datapath.sv
`default_nettype none
// ============================================================================
// voqrr_datapath
// Pointers, working maps, one-input-per-cycle VOQ search (held while the result
// register is blocked), pending grant and result register.
// ============================================================================
module voqrr_datapath
   import voqrr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire cmd_type               cmd,
   output status_type                 status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data
);

   logic [CNT_W-1:0]     src_cnt_ff, dst_cnt_ff;
   logic [SRC_W-1:0]     in_ptr_ff, in_ptr_in;
   logic [DST_W-1:0]     voq_ptr_ff [MAX_SOURCES];
   logic [MAP_W-1:0]     ready_ff, ready_in;
   logic [MAX_DESTS-1:0] free_ff, free_in;
   logic [CNT_W-1:0]     visits_ff, visits_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SRC_W-1:0]     pend_src_ff, pend_src_in;
   logic [DST_W-1:0]     pend_dst_ff, pend_dst_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_data_ff, out_data_in;

   logic [CNT_W-1:0]     ns, nd;
   logic [DST_W-1:0]     start_pos;
   logic [MAX_DESTS-1:0] row;
   logic                 hit;
   logic [DST_W-1:0]     hit_pos;
   logic [DST_W-1:0]     voq_wr;
   logic [SRC_W-1:0]     ip_next;
   logic                 out_can_load;

   assign ns = clamp_count(src_cnt_ff, CNT_W'(MAX_SOURCES));
   assign nd = clamp_count(dst_cnt_ff, CNT_W'(MAX_DESTS));

   assign out_can_load = !out_valid_ff || rsp_ready;
   assign status.out_can_load = out_can_load;
   assign status.scan_more = (|ready_ff) && (|free_ff) && (visits_ff < ns);

   // rotating search from the voq pointer of the current input
   always_comb begin
      logic [CNT_W-1:0] sum;
      logic [CNT_W-1:0] pos;
      start_pos = ({1'b0, voq_ptr_ff[in_ptr_ff]} >= nd) ? '0 : voq_ptr_ff[in_ptr_ff];
      row       = ready_ff[{in_ptr_ff, {DST_W{1'b0}}} +: MAX_DESTS] & free_ff;
      hit       = 1'b0;
      hit_pos   = '0;
      for (int k = 0; k < MAX_DESTS; k++) begin
         sum = {1'b0, start_pos} + CNT_W'(k);
         pos = (sum >= nd) ? sum - nd : sum;
         if ((CNT_W'(k) < nd) && row[pos[DST_W-1:0]] && !hit) begin
            hit     = 1'b1;
            hit_pos = pos[DST_W-1:0];
         end
      end
      voq_wr  = hit ? hit_pos : start_pos;
      ip_next = ({1'b0, in_ptr_ff} + CNT_W'(1) >= ns) ? '0 : in_ptr_ff + SRC_W'(1);
   end

   always_comb begin
      in_ptr_in     = in_ptr_ff;
      ready_in      = ready_ff;
      free_in       = free_ff;
      visits_in     = visits_ff;
      pend_valid_in = pend_valid_ff;
      pend_src_in   = pend_src_ff;
      pend_dst_in   = pend_dst_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_data_in   = out_data_ff;

      if (cmd.start) begin
         in_ptr_in     = ({1'b0, in_ptr_ff} >= ns) ? '0 : in_ptr_ff;
         ready_in      = req_data.ready_map & ready_mask(ns, nd);
         free_in       = req_data.output_free & dest_mask(nd);
         visits_in     = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.step) begin
         in_ptr_in = ip_next;
         visits_in = visits_ff + CNT_W'(1);
         if (hit) begin
            free_in[hit_pos]            = 1'b0;
            ready_in[{in_ptr_ff, hit_pos}] = 1'b0;
            pend_valid_in = 1'b1;
            pend_src_in   = in_ptr_ff;
            pend_dst_in   = hit_pos;
            if (pend_valid_ff) begin
               out_valid_in             = 1'b1;
               out_data_in.grant_valid  = 1'b1;
               out_data_in.grant_source = pend_src_ff;
               out_data_in.grant_dest   = pend_dst_ff;
               out_data_in.last_grant   = 1'b0;
            end
         end
      end

      if (cmd.finish) begin
         out_valid_in             = 1'b1;
         out_data_in.grant_valid  = pend_valid_ff;
         out_data_in.grant_source = pend_valid_ff ? pend_src_ff : '0;
         out_data_in.grant_dest   = pend_valid_ff ? pend_dst_ff : '0;
         out_data_in.last_grant   = 1'b1;
         pend_valid_in            = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_cnt_ff    <= CNT_W'(MAX_SOURCES);
         dst_cnt_ff    <= CNT_W'(MAX_DESTS);
         in_ptr_ff     <= '0;
         for (int i = 0; i < MAX_SOURCES; i++) begin
            voq_ptr_ff[i] <= '0;
         end
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         visits_ff     <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_SOURCES: src_cnt_ff <= csr_data;
               CSR_DESTS:   dst_cnt_ff <= csr_data;
               default: begin
               end
            endcase
         end
         in_ptr_ff     <= in_ptr_in;
         if (cmd.step) begin
            voq_ptr_ff[in_ptr_ff] <= voq_wr;
         end
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         visits_ff     <= visits_in;
      end
   end

   always_ff @(posedge clock) begin
      ready_ff    <= ready_in;
      free_ff     <= free_in;
      pend_src_ff <= pend_src_in;
      pend_dst_ff <= pend_dst_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

FILE: rtl/voq_round_robin_switch_arbiter.sv
`default_nettype none
// ============================================================================
// voq_round_robin_switch_arbiter
// Round-robin crossbar scheduler over virtual output queues.
// ============================================================================
// One request is one switch tick: a map of ready VOQ heads and a map of free
// outputs. The scan visits one input port per cycle while the result register
// can load, starting at the input pointer, and searches that input's VOQs from
// its own pointer in the same cycle. A tick is loaded, then visits inputs (at
// most the active input count, the CSR_SOURCES value held to 1..8, fewer when
// ready heads or free outputs run out), then sees the end of the scan and then
// emits the closing result; scan steps and the closing result stall while a
// held result waits on rsp_ready. Each grant is one result, the last one
// flagged by last_grant; a tick without grants gives one empty result. The
// next request is taken in the cycle after the closing result is loaded.
// ============================================================================
module voq_round_robin_switch_arbiter
   import voqrr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   voqrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   voqrr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.step, cmd.finish}))
      else $error("more than one datapath command");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.grant_valid) |->
         (rsp_data.last_grant && rsp_data.grant_source == '0 && rsp_data.grant_dest == '0))
      else $error("empty result not closing or not zero");

   a_no_req_during_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while scan in progress");

   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.finish) |-> status.out_can_load)
      else $error("scan step with result register blocked");
`endif

endmodule
`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: round-robin VOQ switch arbiter testbench
// Sends switch ticks (ready-head map and free-output map) through the request
// channel and checks every grant against a scan predictor kept in the bench.
// The run walks through several port counts, out-of-range and unused register
// writes, random idling on both channels and a long result-side hold-off.
// ----------------------------------------------------------------------------
module tb;
   import voqrr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 200000;
   localparam int NUM_PHASES   = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = CSR_IDX_W'(15);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   req_type pending_ticks[$];
   rsp_type grant_queue[$];

   logic [CNT_W-1:0] sources_reg = CNT_W'(8);
   logic [CNT_W-1:0] dests_reg   = CNT_W'(8);
   logic [SRC_W-1:0] input_ptr = '0;
   logic [DST_W-1:0] voq_ptr[MAX_SOURCES];

   int  cycles = 0;
   int  errors = 0;
   int  ticks_sent = 0;
   int  grants_seen = 0;
   int  settings_used = 1;
   bit  steady = 1'b0;
   bit  hold_arm = 1'b0;
   bit  hold_used = 1'b0;
   int  hold_left = 0;

   int phase_sources[NUM_PHASES] = '{8, 3, 0, 15, 8, 1, 5, 2};
   int phase_dests[NUM_PHASES]   = '{5, 3, 15, 0, 8, 1, 7, 8};
   int phase_ticks[NUM_PHASES]   = '{30, 30, 25, 25, 40, 20, 40, 30};

   voq_round_robin_switch_arbiter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   function automatic int active_count(input logic [CNT_W-1:0] v, input int lim);
      if (v == '0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   // round-robin scan over inputs, each input searching its own voq pointer
   function automatic void arbitrate_tick(input req_type t);
      int ns, nd, ready_cnt, free_cnt, visits, ip, op, v;
      logic [MAX_DESTS-1:0] free;
      bit hit;
      rsp_type g;
      rsp_type tick_grants[$];
      ns = active_count(sources_reg, MAX_SOURCES);
      nd = active_count(dests_reg, MAX_DESTS);
      free = t.output_free;
      ready_cnt = 0;
      free_cnt = 0;
      visits = 0;
      for (int s = 0; s < ns; s++)
         for (int d = 0; d < nd; d++)
            if (t.ready_map[s*MAX_DESTS+d]) ready_cnt++;
      for (int d = 0; d < nd; d++)
         if (free[d]) free_cnt++;
      if (int'(input_ptr) >= ns) input_ptr = '0;
      while (free_cnt > 0 && ready_cnt > 0 && visits < ns) begin
         ip = int'(input_ptr);
         if (int'(voq_ptr[ip]) >= nd) voq_ptr[ip] = '0;
         hit = 1'b0;
         for (v = 0; v < nd && !hit; v++) begin
            op = int'(voq_ptr[ip]);
            if (t.ready_map[ip*MAX_DESTS+op] && free[op]) begin
               g.grant_valid  = 1'b1;
               g.grant_source = SRC_W'(ip);
               g.grant_dest   = DST_W'(op);
               g.last_grant   = 1'b0;
               tick_grants = {tick_grants, g};
               free[op] = 1'b0;
               free_cnt--;
               ready_cnt--;
               hit = 1'b1;
            end else begin
               voq_ptr[ip] = (op + 1 >= nd) ? '0 : DST_W'(op + 1);
            end
         end
         visits++;
         input_ptr = (ip + 1 >= ns) ? '0 : SRC_W'(ip + 1);
      end
      if (tick_grants.size() == 0) begin
         g = '0;
         g.last_grant = 1'b1;
         tick_grants = {tick_grants, g};
      end
      tick_grants[tick_grants.size()-1].last_grant = 1'b1;
      grant_queue = {grant_queue, tick_grants};
   endfunction

   function automatic logic [MAP_W-1:0] random_map();
      logic [MAP_W-1:0] m;
      m = {$urandom, $urandom};
      case ($urandom_range(3))
         0: ;
         1: m = m & {$urandom, $urandom} & {$urandom, $urandom};
         2: m = m | {$urandom, $urandom};
         default: begin
            m = '0;
            repeat ($urandom_range(1, 4)) m[$urandom_range(MAP_W-1)] = 1'b1;
         end
      endcase
      return m;
   endfunction

   function automatic logic [MAX_DESTS-1:0] random_free();
      logic [MAX_DESTS-1:0] f;
      f = MAX_DESTS'($urandom);
      case ($urandom_range(3))
         0: ;
         1: f = '1;
         2: f = MAX_DESTS'(1) << $urandom_range(MAX_DESTS-1);
         default: f = f & MAX_DESTS'($urandom);
      endcase
      return f;
   endfunction

   function automatic void queue_tick(input logic [MAP_W-1:0] m,
                                      input logic [MAX_DESTS-1:0] f);
      req_type t;
      t.ready_map   = m;
      t.output_free = f;
      pending_ticks = {pending_ticks, t};
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SOURCES) sources_reg = val;
      else if (idx == CSR_DESTS) dests_reg = val;
   endtask

   task automatic drain();
      while (pending_ticks.size() > 0 || req_valid || grant_queue.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic report_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     got_v);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            arbitrate_tick(req_data);
            ticks_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_ticks.size() > 0 && (steady || $urandom_range(99) >= 12)) begin
               req_valid <= 1'b1;
               req_data  <= pending_ticks[0];
               pending_ticks.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long result-side hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // grant monitor
   always @(posedge clock) begin
      rsp_type exp_g;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            grants_seen++;
            if (grant_queue.size() == 0) begin
               errors++;
               if (errors <= 40)
                  $display("%0t: unexpected result, expected none, actual %h", $time,
                           rsp_data);
            end else begin
               exp_g = grant_queue[0];
               grant_queue.delete(0);
               report_field("grant_valid", exp_g.grant_valid, rsp_data.grant_valid);
               report_field("grant_source", exp_g.grant_source, rsp_data.grant_source);
               report_field("grant_dest", exp_g.grant_dest, rsp_data.grant_dest);
               report_field("last_grant", exp_g.last_grant, rsp_data.last_grant);
            end
         end
         rsp_ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("voq_round_robin_switch_arbiter verification failed");
         $finish;
      end
   end

   initial begin
      foreach (voq_ptr[i]) voq_ptr[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed ticks at reset settings
      queue_tick('0, '0);
      queue_tick('1, '1);
      queue_tick('1, '0);
      queue_tick('0, '1);
      queue_tick(MAP_W'(1), MAX_DESTS'(1));
      queue_tick(MAP_W'(1) << (MAP_W-1), MAX_DESTS'(8'h80));
      queue_tick(MAP_W'(1) << (MAP_W-1), MAX_DESTS'(8'h7f));
      queue_tick(MAP_W'(8'hff) << (MAP_W-8), '1);
      queue_tick(MAP_W'(64'h0101010101010101), MAX_DESTS'(1));
      queue_tick(MAP_W'(64'h8040201008040201), '1);
      queue_tick(MAP_W'(64'h8040201008040201), '1);
      queue_tick('1, MAX_DESTS'(8'haa));
      queue_tick(MAP_W'(64'h5555555555555555), MAX_DESTS'(8'h55));
      queue_tick('1, MAX_DESTS'(8'h01));
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_SOURCES, CSR_DATA_W'(phase_sources[p]));
         write_reg(CSR_DESTS, CSR_DATA_W'(phase_dests[p]));
         if (p == 4) begin
            write_reg(CSR_UNUSED_LO, CSR_DATA_W'(1));
            write_reg(CSR_UNUSED_HI, CSR_DATA_W'(0));
         end
         settings_used++;
         @(negedge clock);
         steady = (p == 4);
         if (p == 6) hold_arm = 1'b1;
         repeat (phase_ticks[p]) queue_tick(random_map(), random_free());
         drain();
      end

      $display("covered %0d ticks and %0d grants over %0d port-count settings,",
               ticks_sent, grants_seen, settings_used);
      $display("including clamped and unused register writes and a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("voq_round_robin_switch_arbiter verification clean");
      end else begin
         $display("voq_round_robin_switch_arbiter verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/voqrr_pkg.sv
rtl/voqrr_ctrl.sv
rtl/voqrr_datapath.sv
rtl/voq_round_robin_switch_arbiter.sv
test/tb.sv
